// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL. Each one samples on clk and is
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define AMLD_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another one at the next clock edge.
`define AMLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/amld_pkg.sv =====
`default_nettype none

package amld_pkg;

    // Default length of the moving-average window
    localparam int WINDOW_DEF = 16;

    // Field widths
    localparam int AXIS_W = 16;
    localparam int MAG_W  = 16;
    localparam int THR_W  = 16;
    localparam int STAT_W = 2;
    localparam int SQ_W   = 32;
    localparam int SQRT_STEPS = 16;

    // Reset value of the launch threshold
    localparam logic [THR_W-1:0] THR_RESET = 16'd2509;

    // Detector status codes
    localparam logic [STAT_W-1:0] PH_WAITING = 2'd0;
    localparam logic [STAT_W-1:0] PH_LAUNCH  = 2'd1;
    localparam logic [STAT_W-1:0] PH_LOST    = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SQRT,
        ST_UPDATE,
        ST_EMIT
    } amld_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic square;
        logic sqrt_step;
        logic update;
        logic emit;
    } amld_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic waiting;
    } amld_stat_t;

endpackage

`default_nettype wire

// ===== rtl/amld_ram.sv =====
`default_nettype none

module amld_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/amld_ctrl.sv =====
`default_nettype none

module amld_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire amld_pkg::amld_stat_t stat,
    output amld_pkg::amld_cmd_t      cmd
);

    localparam int CNT_W = $clog2(amld_pkg::SQRT_STEPS);

    amld_pkg::amld_state_t state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;

    // State, counter and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= amld_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            amld_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = amld_pkg::ST_SQUARE;
                end
            end
            amld_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                cnt_next   = '0;
                state_next = amld_pkg::ST_SQRT;
            end
            amld_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(amld_pkg::SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = stat.waiting ? amld_pkg::ST_UPDATE : amld_pkg::ST_EMIT;
                end
            end
            amld_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                cnt_next   = '0;
                state_next = amld_pkg::ST_EMIT;
            end
            amld_pkg::ST_EMIT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = amld_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = amld_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/amld_dp.sv =====
`default_nettype none
`include "assert_macros.svh"

module amld_dp #(
    parameter int WINDOW = amld_pkg::WINDOW_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire amld_pkg::amld_cmd_t           cmd,
    output amld_pkg::amld_stat_t               stat,
    input  wire logic [amld_pkg::AXIS_W-1:0]   in_x,
    input  wire logic [amld_pkg::AXIS_W-1:0]   in_y,
    input  wire logic [amld_pkg::AXIS_W-1:0]   in_z,
    input  wire logic                          in_failed,
    input  wire logic                          cfg_wr_en,
    input  wire logic [amld_pkg::THR_W-1:0]    cfg_wr_data,
    output logic      [amld_pkg::MAG_W-1:0]    out_magnitude,
    output logic      [amld_pkg::MAG_W-1:0]    out_average,
    output logic      [amld_pkg::STAT_W-1:0]   out_status,
    output logic                               out_changed
);

    localparam int MAG_W  = amld_pkg::MAG_W;
    localparam int SQ_W   = amld_pkg::SQ_W;
    localparam int SUM_W  = MAG_W + $clog2(WINDOW);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DIV_K  = SUM_W + $clog2(WINDOW);
    localparam int PROD_W = 2 * SUM_W + 1;
    localparam logic [SUM_W-1:0] WIN_C   = SUM_W'(WINDOW);
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(56755 * WINDOW);
    // Rounded-up reciprocal of the window length, exact for every window sum
    localparam logic [SUM_W:0]   DIV_M   =
        (SUM_W + 1)'(((64'd1 << DIV_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    // Captured sample
    logic [amld_pkg::AXIS_W-1:0] x_reg, y_reg, z_reg;
    logic                        failed_reg;

    // Square-root unit
    logic [SQ_W-1:0] sq_rem_reg, sq_root_reg, sq_bit_reg;

    // Window bookkeeping
    logic [SUM_W-1:0]            sum_reg;
    logic [SUM_W-1:0]            thr_prod_reg;
    logic [amld_pkg::THR_W-1:0]  thr_reg;
    logic [SLOT_W-1:0]           slot_reg;
    logic                        wrapped_reg;
    logic [amld_pkg::STAT_W-1:0] phase_reg;
    logic                        changed_reg;

    logic [MAG_W-1:0] ram_rd_data;
    logic [MAG_W-1:0] old_mag;
    logic [MAG_W-1:0] new_mag;
    logic [SUM_W-1:0] sum_new;
    logic             win_we;

    logic [MAG_W-1:0] ax, ay, az;
    logic [SQ_W-1:0]  sq_sum;
    logic [SQ_W-1:0]  sq_trial;
    logic             sq_take;

    logic [PROD_W-1:0] avg_prod;
    logic [MAG_W-1:0]  avg_new;
    logic              decided;

    // Magnitude of each axis; the most negative code maps to 32768
    always_comb
    begin
        ax     = x_reg[MAG_W-1] ? (~x_reg + 16'd1) : x_reg;
        ay     = y_reg[MAG_W-1] ? (~y_reg + 16'd1) : y_reg;
        az     = z_reg[MAG_W-1] ? (~z_reg + 16'd1) : z_reg;
        sq_sum = (SQ_W'(ax) * SQ_W'(ax)) + (SQ_W'(ay) * SQ_W'(ay))
               + (SQ_W'(az) * SQ_W'(az));
    end

    // One square-root step: try to take root plus bit from the remainder
    always_comb
    begin
        sq_trial = sq_root_reg + sq_bit_reg;
        sq_take  = (sq_rem_reg >= sq_trial);
    end

    assign new_mag = sq_root_reg[MAG_W-1:0];

    // Window update: drop the oldest entry, add the new one
    always_comb
    begin
        old_mag = wrapped_reg ? ram_rd_data : '0;
        sum_new = sum_reg - SUM_W'(old_mag) + SUM_W'(new_mag);
        win_we  = cmd.update && (phase_reg == amld_pkg::PH_WAITING) && !failed_reg;
    end

    // Window average: multiply the sum by the reciprocal and keep the top bits
    always_comb
    begin
        avg_prod = PROD_W'(sum_reg) * PROD_W'(DIV_M);
        avg_new  = avg_prod[DIV_K +: MAG_W];
    end

    // Capture sample and run the square root
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg        <= in_x;
            y_reg        <= in_y;
            z_reg        <= in_z;
            failed_reg   <= in_failed;
            thr_prod_reg <= SUM_W'(thr_reg) * WIN_C;
        end
        if (cmd.square)
        begin
            sq_rem_reg  <= failed_reg ? '0 : sq_sum;
            sq_root_reg <= '0;
            sq_bit_reg  <= SQ_W'(1) << (SQ_W - 2);
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_take)
            begin
                sq_rem_reg  <= sq_rem_reg - sq_trial;
                sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_root_reg <= sq_root_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    // Detector state, window pointer and threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= amld_pkg::THR_RESET;
            sum_reg     <= '0;
            slot_reg    <= '0;
            wrapped_reg <= 1'b0;
            phase_reg   <= amld_pkg::PH_WAITING;
            changed_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                changed_reg <= 1'b0;
            end
            if (cmd.update && phase_reg == amld_pkg::PH_WAITING)
            begin
                if (failed_reg)
                begin
                    phase_reg   <= amld_pkg::PH_LOST;
                    changed_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= sum_new;
                    if (slot_reg == SLOT_W'(WINDOW - 1))
                    begin
                        slot_reg    <= '0;
                        wrapped_reg <= 1'b1;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                    if (sum_new >= thr_prod_reg)
                    begin
                        phase_reg   <= amld_pkg::PH_LAUNCH;
                        changed_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_magnitude <= new_mag;
            out_average   <= avg_new;
            out_status    <= phase_reg;
            out_changed   <= changed_reg;
        end
    end

    // Magnitude window
    amld_ram #(
        .WIDTH (MAG_W),
        .DEPTH (WINDOW)
    ) u_window (
        .clk     (clk),
        .wr_en   (win_we),
        .wr_addr (slot_reg),
        .wr_data (new_mag),
        .rd_en   (cmd.square),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    assign stat.waiting = (phase_reg == amld_pkg::PH_WAITING);
    assign decided      = (phase_reg != amld_pkg::PH_WAITING);

    `AMLD_ASSERT_NEXT(a_phase_sticky, decided, $stable(phase_reg), "decided status changed")
    `AMLD_ASSERT_NEXT(a_sum_frozen, decided, $stable(sum_reg), "window sum moved after decision")
    `AMLD_ASSERT_NOW(a_changed_decided, !changed_reg || decided, "change flag set while waiting")
    `AMLD_ASSERT_NOW(a_sum_bound, sum_reg <= SUM_MAX, "window sum out of range")

endmodule

`default_nettype wire

// ===== rtl/accel_magnitude_launch_detector_core.sv =====
`default_nettype none

// Launch detector on accelerometer magnitude. Each input beat carries one
// three-axis sample (x, y, z in tdata, read_failed in tuser); each one gives
// exactly one output beat with the floored vector magnitude, the average of
// the last WINDOW magnitudes (window starts as zeros after reset), the status
// (0 waiting, 1 launch, 2 sensor lost) and a flag on the beat where status
// first left waiting. Launch is declared when sum >= threshold * WINDOW; a
// failed read while waiting declares the sensor lost; both are sticky until
// reset, and after that the window and average are frozen. Items are handled
// one at a time: while the detector is waiting an item runs from one accept
// to the next through capture, squaring, 16 square-root steps, window
// update and emit, and after a decision the update step is skipped.
// The average is the window sum times a constant reciprocal of
// WINDOW. A finished result waits in the output register while the next
// sample is taken; a later result stalls the block until that register is
// free. The threshold register may be written only while no item is in flight.
module accel_magnitude_launch_detector_core #(
    parameter int WINDOW = amld_pkg::WINDOW_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    input  wire logic        s_axis_tuser,   // read_failed[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,   // magnitude[15:0], window_average[31:16],
                                             // status[33:32], status_changed[34], zero[39:35]
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data     // launch_threshold
);

    amld_pkg::amld_cmd_t  cmd;
    amld_pkg::amld_stat_t stat;

    logic [amld_pkg::MAG_W-1:0]  out_magnitude;
    logic [amld_pkg::MAG_W-1:0]  out_average;
    logic [amld_pkg::STAT_W-1:0] out_status;
    logic                        out_changed;

    // Sequencer
    amld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Square root, window and average
    amld_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_x          (s_axis_tdata[15:0]),
        .in_y          (s_axis_tdata[31:16]),
        .in_z          (s_axis_tdata[47:32]),
        .in_failed     (s_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_magnitude (out_magnitude),
        .out_average   (out_average),
        .out_status    (out_status),
        .out_changed   (out_changed)
    );

    // Pack the result beat
    assign m_axis_tdata = {5'd0, out_changed, out_status, out_average, out_magnitude};

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN = amld_pkg::WINDOW_DEF;

    // Kinds of random axis reading
    localparam int MODE_FULL   = 0;
    localparam int MODE_SMALL  = 1;
    localparam int MODE_CORNER = 2;

    // Ways the run may end
    localparam int END_LOST = 0;
    localparam int END_ZERO = 1;
    localparam int END_RISE = 2;

    // Expected contents of one output beat
    typedef struct {
        logic [amld_pkg::MAG_W-1:0]  magnitude;
        logic [amld_pkg::MAG_W-1:0]  average;
        logic [amld_pkg::STAT_W-1:0] status;
        logic                        changed;
    } detector_result_t;

    // Shadow of the detector: window, sum, phase and threshold, plus the
    // results that are still owed by the block.
    class launch_scoreboard;
        logic [amld_pkg::MAG_W-1:0]  mag_window [WIN];
        int                          write_pos;
        logic [31:0]                 window_sum;
        logic [amld_pkg::STAT_W-1:0] phase;
        logic [amld_pkg::THR_W-1:0]  threshold;
        detector_result_t            owed_results [$];
        int                          mismatches;
        int                          checked;
        int                          failed_reads;

        function new();
            foreach (mag_window[i])
                mag_window[i] = '0;
            write_pos    = 0;
            window_sum   = '0;
            phase        = amld_pkg::PH_WAITING;
            threshold    = amld_pkg::THR_RESET;
            mismatches   = 0;
            checked      = 0;
            failed_reads = 0;
        endfunction

        function void set_threshold(logic [amld_pkg::THR_W-1:0] value);
            threshold = value;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Absolute value of a two's complement axis reading
        function longint unsigned axis_abs(logic [amld_pkg::AXIS_W-1:0] v);
            if (v[amld_pkg::AXIS_W-1])
                return 64'd65536 - {48'd0, v};
            return {48'd0, v};
        endfunction

        // Floored square root, one result bit per pass from the top
        function logic [amld_pkg::MAG_W-1:0] floor_root(longint unsigned n);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = amld_pkg::MAG_W - 1; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= n)
                    root = trial;
            end
            return root[amld_pkg::MAG_W-1:0];
        endfunction

        // Apply one accepted sample and queue the beat it must produce
        function void note_input(logic [amld_pkg::AXIS_W-1:0] x,
                                 logic [amld_pkg::AXIS_W-1:0] y,
                                 logic [amld_pkg::AXIS_W-1:0] z, logic failed);
            detector_result_t           r;
            longint unsigned            ax;
            longint unsigned            ay;
            longint unsigned            az;
            logic [amld_pkg::MAG_W-1:0] mag;
            logic                       changed;
            changed = 1'b0;
            mag     = '0;
            if (failed)
                failed_reads++;
            else
            begin
                ax  = axis_abs(x);
                ay  = axis_abs(y);
                az  = axis_abs(z);
                mag = floor_root(ax * ax + ay * ay + az * az);
            end
            // Window and sum move only while no decision has been made
            if (phase == amld_pkg::PH_WAITING)
            begin
                if (failed)
                begin
                    phase   = amld_pkg::PH_LOST;
                    changed = 1'b1;
                end
                else
                begin
                    window_sum = window_sum - mag_window[write_pos] + mag;
                    mag_window[write_pos] = mag;
                    write_pos = (write_pos + 1) % WIN;
                    if (64'(window_sum) >= 64'(threshold) * WIN)
                    begin
                        phase   = amld_pkg::PH_LAUNCH;
                        changed = 1'b1;
                    end
                end
            end
            r.magnitude  = mag;
            r.average    = amld_pkg::MAG_W'(window_sum / WIN);
            r.status     = phase;
            r.changed    = changed;
            owed_results = {owed_results, r};
        endfunction

        // Compare one output beat against the oldest owed result
        function void check_result(logic [39:0] beat);
            detector_result_t r;
            if (owed_results.size() == 0)
            begin
                $display("%0t: output beat with nothing owed, data %h", $time, beat);
                mismatches++;
                return;
            end
            r = owed_results.pop_front();
            checked++;
            if (beat[15:0] !== r.magnitude)
            begin
                $display("%0t: magnitude expected %0d actual %0d",
                         $time, r.magnitude, beat[15:0]);
                mismatches++;
            end
            if (beat[31:16] !== r.average)
            begin
                $display("%0t: window_average expected %0d actual %0d",
                         $time, r.average, beat[31:16]);
                mismatches++;
            end
            if (beat[33:32] !== r.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, r.status, beat[33:32]);
                mismatches++;
            end
            if (beat[34] !== r.changed)
            begin
                $display("%0t: status_changed expected %0d actual %0d",
                         $time, r.changed, beat[34]);
                mismatches++;
            end
            if (beat[39:35] !== 5'd0)
            begin
                $display("%0t: pad bits expected 0 actual %b", $time, beat[39:35]);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    launch_scoreboard sb;
    bit  idle_on;
    bit  rx_hold_req;
    int  beats_sent;
    int  threshold_writes;

    accel_magnitude_launch_detector_core #(
        .WINDOW (WIN)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tuser);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Output side: random stall bursts, and one long hold on request
    initial
    begin
        int n;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 5);
                repeat (n - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one sample beat, with an optional gap first, and hold it until taken
    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                               logic failed);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tuser  <= failed;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    // Drop valid and let every owed result drain
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write the threshold while the block is idle
    task automatic write_threshold(logic [15:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        sb.set_threshold(value);
        threshold_writes++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // One random axis reading: full range, small, or a corner value
    function automatic logic [15:0] pick_axis(int mode);
        case (mode)
            MODE_FULL:  return 16'($urandom);
            MODE_SMALL: return 16'($urandom_range(0, 4000) - 2000);
            default:
                case ($urandom_range(0, 4))
                    0: return 16'h0000;
                    1: return 16'h0001;
                    2: return 16'hFFFF;
                    3: return 16'h7FFF;
                    default: return 16'h8000;
                endcase
        endcase
    endfunction

    task automatic send_random(int mode);
        send_sample(pick_axis(mode), pick_axis(mode), pick_axis(mode), 1'b0);
    endtask

    // Large reading with random sign, magnitude per axis at least 29000
    function automatic logic [15:0] big_axis();
        logic [15:0] v;
        v = 16'($urandom_range(29000, 32767));
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    initial
    begin
        int    ending;
        int    limit;
        bit    timed_out;
        string ending_name;

        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        idle_on     = 1'b1;
        rx_hold_req = 1'b0;
        beats_sent  = 0;
        threshold_writes = 0;
        timed_out   = 1'b0;
        sb = new();

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Small samples at the reset threshold; the zeroed window drags the average
        send_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_sample(16'h0001, 16'h0000, 16'h0000, 1'b0);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_sample(16'd3, 16'd4, 16'd0, 1'b0);
        send_sample(16'd0, 16'd0, 16'd2000, 1'b0);

        // Highest threshold can never be reached: try the axis extremes
        write_threshold(16'hFFFF);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_sample(16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_sample(16'h8000, 16'h0000, 16'h0000, 1'b0);
        send_sample(16'h0000, 16'h7FFF, 16'h0000, 1'b0);
        send_sample(16'h0000, 16'h0000, 16'h8000, 1'b0);
        send_sample(16'h7FFF, 16'h8000, 16'h0001, 1'b0);
        send_sample(16'h5555, 16'hAAAA, 16'h00FF, 1'b0);
        // Fill 13 of the 16 window slots with the largest magnitude to push the sum up
        repeat (13) send_sample(16'h8000, 16'h8000, 16'h8000, 1'b0);

        // Just above the largest magnitude: still unreachable
        write_threshold(16'd56756);
        repeat (450) send_random($urandom_range(MODE_FULL, MODE_CORNER));
        drain_results();
        repeat (50) send_random($urandom_range(MODE_FULL, MODE_CORNER));

        // Small samples under a low threshold that they cannot reach
        write_threshold(16'($urandom_range(3500, 8000)));
        repeat (450) send_random(MODE_SMALL);

        // Long output hold while input keeps coming, so the block backs up
        write_threshold(16'hFFFF);
        rx_hold_req = 1'b1;
        repeat (30) send_random(MODE_FULL);
        repeat (420) send_random($urandom_range(MODE_FULL, MODE_CORNER));

        // Last stretch with no idling on either side
        write_threshold(16'($urandom_range(48000, 65535)));
        idle_on = 1'b0;
        repeat (350) send_random($urandom_range(MODE_FULL, MODE_SMALL));

        // Finish with one decision, chosen at random
        ending = $urandom_range(END_LOST, END_RISE);
        if (ending == END_LOST)
        begin
            ending_name = "sensor lost on a failed read";
            send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        end
        else if (ending == END_ZERO)
        begin
            ending_name = "launch at zero threshold";
            write_threshold(16'h0000);
            send_random(MODE_SMALL);
        end
        else
        begin
            ending_name = "launch on a rising average";
            write_threshold(16'($urandom_range(20000, 50000)));
            limit = 0;
            while (sb.phase == amld_pkg::PH_WAITING && limit < 40)
            begin
                send_sample(big_axis(), big_axis(), big_axis(), 1'b0);
                limit++;
            end
        end

        // Frozen window: good and failed reads after the decision
        repeat (80)
            send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                        1'($urandom_range(0, 1)));

        // Wait for the last results, with a limit
        @(negedge clk);
        s_tvalid <= 1'b0;
        limit = 0;
        while (sb.pending() != 0 && limit < 20000)
        begin
            @(posedge clk);
            limit++;
        end
        if (sb.pending() != 0)
            timed_out = 1'b1;
        else
            repeat (60) @(posedge clk);

        if (timed_out)
        begin
            $display("%0t: %0d results never arrived", $time, sb.pending());
            $display("testbench: done, errors");
            $finish;
        end
        else
        begin
            $display("summary: %0d samples sent (%0d failed reads), %0d results checked",
                     beats_sent, sb.failed_reads, sb.checked);
            $display("summary: %0d threshold writes, run ended with %s",
                     threshold_writes, ending_name);
            if (sb.mismatches == 0)
                $display("testbench: done, clean");
            else
                $display("testbench: done, errors");
            $finish;
        end
    end

endmodule

`default_nettype wire
